// File: rtl/omni_ik_pkg.sv
// Shared types and constants for the omni base inverse kinematics block.
`timescale 1ns / 1ps

package omni_ik_pkg;

  // Default resolution of the quarter-wave sine table (address bits)
  localparam int unsigned SINE_TABLE_BITS = 10;

  // Field widths
  localparam int unsigned VelW    = 16;
  localparam int unsigned AngleW  = 16;
  localparam int unsigned RadiusW = 16;
  localparam int unsigned WheelW  = 20;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgW    = 16;

  // Binary angle offsets: quarter turn and eighth turn
  localparam logic [AngleW-1:0] QuarterTurn = 16'd16384;
  localparam logic [AngleW-1:0] EighthTurn  = 16'd8192;

  // Register reset values
  localparam logic               FrameModeRst   = 1'b0;
  localparam logic [RadiusW-1:0] WheelRadiusRst = 16'd256;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FRAME_MODE   = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_WHEEL_RADIUS = 4'd1;

  // Depth of the command queue between front and back
  localparam int unsigned QueueDepth = 2;

  // One velocity request as it travels from front to back
  typedef struct packed {
    logic signed [VelW-1:0] vel_x;
    logic signed [VelW-1:0] vel_y;
    logic signed [VelW-1:0] turn_rate;
    logic [AngleW-1:0]      phi;
  } cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/omni_ik_front.sv
// Front end: configuration registers, request intake and angle preparation.
`timescale 1ns / 1ps

module omni_ik_front
  import omni_ik_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic signed [VelW-1:0] vel_x_i,
  input  logic signed [VelW-1:0] vel_y_i,
  input  logic signed [VelW-1:0] turn_rate_i,
  input  logic [AngleW-1:0]   heading_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  q_status_t           q_status_i,
  output logic                push_o,
  output cmd_t                cmd_o,
  output logic [RadiusW-1:0]  wheel_radius_o
);

  logic               frame_mode_q, frame_mode_d;
  logic [RadiusW-1:0] wheel_radius_q, wheel_radius_d;
  logic [AngleW-1:0]  rot_angle;

  // Always take configuration writes
  assign cfg_ready_o = 1'b1;

  // Decode register writes; drop unknown indexes
  always_comb begin
    frame_mode_d   = frame_mode_q;
    wheel_radius_d = wheel_radius_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_MODE:   frame_mode_d   = cfg_data_i[0];
        CFG_WHEEL_RADIUS: wheel_radius_d = cfg_data_i[RadiusW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_mode_q   <= FrameModeRst;
      wheel_radius_q <= WheelRadiusRst;
    end else begin
      frame_mode_q   <= frame_mode_d;
      wheel_radius_q <= wheel_radius_d;
    end
  end

  assign wheel_radius_o = wheel_radius_q;

  // Hold off requests only when the queue has no room
  assign busy_o = q_status_i.full;
  assign push_o = start_i && !q_status_i.full;

  // Rotation angle: heading plus a quarter turn in field frame, zero in robot frame
  assign rot_angle = frame_mode_q ? '0 : heading_i + QuarterTurn;

  // Fold the eighth-turn offset in here so the back end reads the table directly
  always_comb begin
    cmd_o.vel_x     = vel_x_i;
    cmd_o.vel_y     = vel_y_i;
    cmd_o.turn_rate = turn_rate_i;
    cmd_o.phi       = rot_angle + EighthTurn;
  end

endmodule

// File: rtl/omni_ik_queue.sv
// Short request queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module omni_ik_queue
  import omni_ik_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      push_data_i,
  input  logic      pop_i,
  output cmd_t      pop_data_o,
  output q_status_t status_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            slots_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign status_o.full  = (count_q == CntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  // Advance pointers with wraparound at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = slots_q[rd_ptr_q];

endmodule

// File: rtl/omni_ik_back.sv
// Back end: sine lookup, products, wheel sums, rounding and saturation.
`timescale 1ns / 1ps

module omni_ik_back
  import omni_ik_pkg::*;
#(
  parameter int unsigned SineTableBits = SINE_TABLE_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  q_status_t                 q_status_i,
  input  cmd_t                      cmd_i,
  output logic                      pop_o,
  input  logic [RadiusW-1:0]        wheel_radius_i,
  output logic                      result_valid_o,
  output logic signed [WheelW-1:0]  wheel_a_o,
  output logic signed [WheelW-1:0]  wheel_b_o,
  output logic signed [WheelW-1:0]  wheel_c_o,
  output logic signed [WheelW-1:0]  wheel_d_o,
  output logic                      clipped_o
);

  localparam int unsigned TblEntries = (1 << SineTableBits) + 1;
  localparam int unsigned AddrW      = SineTableBits + 1;
  localparam int unsigned MagW       = 15;
  localparam int unsigned KW         = 16;
  localparam int unsigned ProdW      = VelW + KW;
  localparam int unsigned RwW        = RadiusW + 1 + VelW;
  localparam int unsigned SumW       = RwW + 9;
  localparam int unsigned RndW       = SumW - 15;
  localparam logic [63:0] HalfPiQ30  = 64'd1686629713;

  typedef logic [MagW-1:0] rom_t [TblEntries];

  // One quarter-wave entry: Taylor series in Q30, rounded to Q0.15
  function automatic logic [MagW-1:0] sine_entry(input logic [63:0] i);
    logic [63:0]        theta;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    theta = (i * HalfPiQ30) >> SineTableBits;
    t     = theta;
    sum   = $signed(theta);
    for (int k = 1; k <= 7; k++) begin
      t = (t * theta) >> 30;
      t = (t * theta) >> 30;
      case (k)
        1:       t = t / 64'd6;
        2:       t = t / 64'd20;
        3:       t = t / 64'd42;
        4:       t = t / 64'd72;
        5:       t = t / 64'd110;
        6:       t = t / 64'd156;
        default: t = t / 64'd210;
      endcase
      if (k % 2 == 1) begin
        sum = sum - $signed(t);
      end else begin
        sum = sum + $signed(t);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum + 64'sd16384) >>> 15;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end
    return r[MagW-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    for (int i = 0; i < TblEntries; i++) begin
      rom[i] = sine_entry(64'(i));
    end
    return rom;
  endfunction

  localparam rom_t SineRom = build_rom();

  // Stage valid bits
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;

  // Stage 1: table reads
  logic [1:0]             s1_quad_q;
  logic signed [VelW-1:0] s1_vx_q, s1_vy_q, s1_w_q;
  logic [MagW-1:0]        s1_lo_q, s1_hi_q;
  logic [AddrW-1:0]       idx_lo, idx_hi;

  // Stage 2: products
  logic signed [KW-1:0]    k1, k2;
  logic [MagW-1:0]         k1_mag, k2_mag;
  logic                    k1_neg, k2_neg;
  logic signed [ProdW-1:0] s2_vx_k1_q, s2_vx_k2_q, s2_vy_k1_q, s2_vy_k2_q;
  logic signed [RwW-1:0]   s2_rw_q;

  // Stage 3: wheel sums
  logic signed [SumW-1:0] rw_ext, vxk1, vxk2, vyk1, vyk2;
  logic signed [SumW-1:0] s3_sum_q [4];

  // Stage 4: rounding and saturation
  logic signed [WheelW-1:0] sat [4];
  logic [3:0]               clip;

  // Pop whenever a request waits: the back end never stalls
  assign pop_o = !q_status_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= pop_o;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  // Read both mirror entries of the quarter-wave table
  assign idx_lo = {1'b0, cmd_i.phi[13 -: SineTableBits]};
  assign idx_hi = AddrW'(1 << SineTableBits) - idx_lo;

  always_ff @(posedge clk_i) begin
    s1_quad_q <= cmd_i.phi[AngleW-1 -: 2];
    s1_vx_q   <= cmd_i.vel_x;
    s1_vy_q   <= cmd_i.vel_y;
    s1_w_q    <= cmd_i.turn_rate;
    s1_lo_q   <= SineRom[idx_lo];
    s1_hi_q   <= SineRom[idx_hi];
  end

  // Pick quadrant and sign: k1 = sin(phi), k2 = sin(phi + quarter turn)
  assign k1_mag = s1_quad_q[0] ? s1_hi_q : s1_lo_q;
  assign k2_mag = s1_quad_q[0] ? s1_lo_q : s1_hi_q;
  assign k1_neg = s1_quad_q[1];
  assign k2_neg = s1_quad_q[1] ^ s1_quad_q[0];
  assign k1 = k1_neg ? -$signed({1'b0, k1_mag}) : $signed({1'b0, k1_mag});
  assign k2 = k2_neg ? -$signed({1'b0, k2_mag}) : $signed({1'b0, k2_mag});

  always_ff @(posedge clk_i) begin
    s2_vx_k1_q <= s1_vx_q * k1;
    s2_vx_k2_q <= s1_vx_q * k2;
    s2_vy_k1_q <= s1_vy_q * k1;
    s2_vy_k2_q <= s1_vy_q * k2;
    s2_rw_q    <= $signed({1'b0, wheel_radius_i}) * s1_w_q;
  end

  // Align R*w to the product scale and sign-extend everything to the sum width
  assign rw_ext = {{2{s2_rw_q[RwW-1]}}, s2_rw_q, 7'b0};
  assign vxk1   = SumW'(s2_vx_k1_q);
  assign vxk2   = SumW'(s2_vx_k2_q);
  assign vyk1   = SumW'(s2_vy_k1_q);
  assign vyk2   = SumW'(s2_vy_k2_q);

  always_ff @(posedge clk_i) begin
    s3_sum_q[0] <= rw_ext - vxk1 + vyk2;
    s3_sum_q[1] <= rw_ext - vxk2 - vyk1;
    s3_sum_q[2] <= rw_ext + vxk1 - vyk2;
    s3_sum_q[3] <= rw_ext + vxk2 + vyk1;
  end

  // Round half up to Q.0 at the velocity scale (floor after adding half an LSB), then clamp to 20 bits
  always_comb begin
    logic signed [SumW-1:0] biased;
    logic signed [RndW-1:0] rounded;
    for (int j = 0; j < 4; j++) begin
      biased  = s3_sum_q[j] + SumW'(16384);
      rounded = biased[SumW-1:15];
      if (rounded > RndW'(524287)) begin
        sat[j]  = 20'sd524287;
        clip[j] = 1'b1;
      end else if (rounded < -RndW'(524288)) begin
        sat[j]  = -20'sd524288;
        clip[j] = 1'b1;
      end else begin
        sat[j]  = rounded[WheelW-1:0];
        clip[j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wheel_a_o <= sat[0];
    wheel_b_o <= sat[1];
    wheel_c_o <= sat[2];
    wheel_d_o <= sat[3];
    clipped_o <= |clip;
  end

  assign result_valid_o = s4_valid_q;

endmodule

// File: rtl/omni_four_wheel_inverse_kinematics.sv
// Top level of the four-wheel omni X-drive inverse kinematics block.
//
// Usage:
//   Requests arrive on start with vel_x_i, vel_y_i, turn_rate_i and heading_i;
//   a request is taken at a clock edge where start is high and busy is low.
//   Each request gives one result: the four wheel speeds and the clipped flag,
//   shown for exactly one cycle with result_valid_o high.
//   A taken request passes through one queue slot and the table read, multiply,
//   sum and round/saturate registers before it reaches the result ports.
//   Throughput: one request per cycle; the back end pops the queue whenever it
//   holds a request, so the two-entry queue never fills and busy stays low.
//   Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   index 0 is frame_mode (bit 0), index 1 is wheel_radius; other indexes are
//   ignored. cfg_ready_o is always high. Write only while the block is idle.
//   Reset: frame_mode returns to field frame, wheel_radius to 1.0, the queue and
//   pipeline empty. The sine table is a constant ROM and needs no fill.
//   The receiver cannot stall; results are dropped if not taken in their cycle.
`timescale 1ns / 1ps

module omni_four_wheel_inverse_kinematics
  import omni_ik_pkg::*;
#(
  parameter int unsigned SineTableBits = SINE_TABLE_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [VelW-1:0]   vel_x_i,
  input  logic signed [VelW-1:0]   vel_y_i,
  input  logic signed [VelW-1:0]   turn_rate_i,
  input  logic [AngleW-1:0]        heading_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgW-1:0]          cfg_data_i,
  output logic                     result_valid_o,
  output logic signed [WheelW-1:0] wheel_a_o,
  output logic signed [WheelW-1:0] wheel_b_o,
  output logic signed [WheelW-1:0] wheel_c_o,
  output logic signed [WheelW-1:0] wheel_d_o,
  output logic                     clipped_o
);

  q_status_t          q_status;
  logic               push, pop;
  cmd_t               push_cmd, pop_cmd;
  logic [RadiusW-1:0] wheel_radius;

  // Intake and configuration
  omni_ik_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .vel_x_i       (vel_x_i),
    .vel_y_i       (vel_y_i),
    .turn_rate_i   (turn_rate_i),
    .heading_i     (heading_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .wheel_radius_o(wheel_radius)
  );

  // Decoupling queue
  omni_ik_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .pop_i      (pop),
    .pop_data_o (pop_cmd),
    .status_o   (q_status)
  );

  // Arithmetic pipeline
  omni_ik_back #(
    .SineTableBits(SineTableBits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_status_i    (q_status),
    .cmd_i         (pop_cmd),
    .pop_o         (pop),
    .wheel_radius_i(wheel_radius),
    .result_valid_o(result_valid_o),
    .wheel_a_o     (wheel_a_o),
    .wheel_b_o     (wheel_b_o),
    .wheel_c_o     (wheel_c_o),
    .wheel_d_o     (wheel_d_o),
    .clipped_o     (clipped_o)
  );

  // Every taken request raises result_valid_o, and no other strobe appears
  a_result_follows_request : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    result_valid_o == $past(start && !busy && rst_ni, 5)
  ) else $error("result strobe does not match request five cycles earlier");

  // The back end drains one request per cycle, so the queue never backs up
  a_never_busy : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !busy
  ) else $error("request queue filled up");

  // A popped request always enters the pipeline on the next edge
  a_pop_enters_pipe : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    pop |=> u_back.s1_valid_q
  ) else $error("popped request lost before the pipeline");

endmodule
